### design/lbpi_pkg.sv
`default_nettype none

package lbpi_pkg;

  localparam int MAX_PATTERNS = 64;
  localparam int TBL_AW       = $clog2(MAX_PATTERNS);
  localparam int HIST_W       = 10;
  localparam int AREA_W       = 20;
  localparam int AGE_W        = 8;
  localparam int PHASE_W      = 4;
  localparam int IDX_W        = 6;
  localparam int CNT_W        = 7;
  localparam int STATUS_W     = 3;
  localparam int PROD_W       = AREA_W + 4;

  localparam logic [AGE_W-1:0] AGE_MATURE = 8'd9;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEW   = 3'd0,
    ST_REC   = 3'd1,
    ST_NONE  = 3'd2,
    ST_NEAR  = 3'd3,
    ST_EXACT = 3'd4
  } lbpi_status_t;

  // controller to datapath
  typedef struct packed {
    logic tbl_write;
    logic load;
    logic update;
    logic search_start;
    logic search;
    logic capture;
    logic out_load;
  } lbpi_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_write;
    logic skip_search;
    logic empty;
    logic hit;
    logic last;
  } lbpi_sts_t;

  // (phase + 1) mod 10 for any 4-bit phase
  function automatic logic [PHASE_W-1:0] rot_amount(input logic [PHASE_W-1:0] phase);
    logic [PHASE_W:0] p1;
    p1 = {1'b0, phase} + 5'd1;
    if (p1 >= 5'd10) begin
      p1 = p1 - 5'd10;
    end
    return p1[PHASE_W-1:0];
  endfunction

  function automatic logic [HIST_W-1:0] rotl_hist(input logic [HIST_W-1:0] h,
                                                  input logic [PHASE_W-1:0] r);
    logic [2*HIST_W-1:0] dbl;
    dbl = {h, h} << r;
    return dbl[2*HIST_W-1:HIST_W];
  endfunction

endpackage

`default_nettype wire

### design/lbpi_if.sv
`default_nettype none

interface lbpi_item_if;
  import lbpi_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [AREA_W-1:0]    area;
  logic [AREA_W-1:0]    prev_area;
  logic [AGE_W-1:0]     age;
  logic [HIST_W-1:0]    old_pattern;
  logic [PHASE_W-1:0]   phase;
  logic                 last_in_frame;
  logic [IDX_W-1:0]     table_index;
  logic [HIST_W-1:0]    table_value;

  modport source (output valid, func, area, prev_area, age, old_pattern, phase,
                  last_in_frame, table_index, table_value, input ready);
  modport sink (input valid, func, area, prev_area, age, old_pattern, phase,
                last_in_frame, table_index, table_value, output ready);
endinterface

interface lbpi_result_if;
  import lbpi_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [HIST_W-1:0]    new_pattern;
  logic [STATUS_W-1:0]  status;
  logic [IDX_W-1:0]     led_id;
  logic                 frame_end;

  modport source (output valid, new_pattern, status, led_id, frame_end, input ready);
  modport sink (input valid, new_pattern, status, led_id, frame_end, output ready);
endinterface

`default_nettype wire

### design/lbpi_ctrl.sv
`default_nettype none

module lbpi_ctrl
  import lbpi_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire lbpi_sts_t sts,
  output lbpi_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_SEARCH,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (sts.is_write) begin
            cmd.tbl_write = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = S_UPDATE;
          end
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        if (sts.skip_search || sts.empty) begin
          state_next = S_FINISH;
        end else begin
          cmd.search_start = 1'b1;
          state_next       = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.search = 1'b1;
        if (sts.hit) begin
          cmd.capture = 1'b1;
          state_next  = S_FINISH;
        end else if (sts.last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_update_after_accept: assert property (@(posedge clk) disable iff (rst)
    state == S_UPDATE |-> $past(in_valid && in_ready && !sts.is_write))
    else $error("update state entered without an observation transaction");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten while full");

  a_first_search_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH && $past(state) == S_UPDATE) |-> (!sts.hit && !sts.last))
    else $error("table compare before read data is available");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FINISH)
    else $error("result raised outside finish state");

endmodule

`default_nettype wire

### design/lbpi_dp.sv
`default_nettype none

module lbpi_dp
  import lbpi_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CNT_W-1:0]    cfg_wdata,
  input  wire logic                func,
  input  wire logic [AREA_W-1:0]   area,
  input  wire logic [AREA_W-1:0]   prev_area,
  input  wire logic [AGE_W-1:0]    age,
  input  wire logic [HIST_W-1:0]   old_pattern,
  input  wire logic [PHASE_W-1:0]  phase,
  input  wire logic                last_in_frame,
  input  wire logic [IDX_W-1:0]    table_index,
  input  wire logic [HIST_W-1:0]   table_value,
  input  wire lbpi_cmd_t           cmd,
  output lbpi_sts_t                sts,
  output logic [HIST_W-1:0]        new_pattern,
  output logic [STATUS_W-1:0]      status,
  output logic [IDX_W-1:0]         led_id,
  output logic                     frame_end
);

  logic [CNT_W-1:0]   pattern_count;
  logic [CNT_W-1:0]   limit;

  logic [AREA_W-1:0]  area_q;
  logic [AREA_W-1:0]  prev_area_q;
  logic [AGE_W-1:0]   age_q;
  logic [HIST_W-1:0]  old_q;
  logic [PHASE_W-1:0] phase_q;
  logic               frame_end_q;

  logic [HIST_W-1:0]  hist_q;
  logic [HIST_W-1:0]  rot_q;
  lbpi_status_t       res_status;
  logic [TBL_AW-1:0]  res_id;

  logic [HIST_W-1:0]  tbl_mem [MAX_PATTERNS];
  logic [TBL_AW-1:0]  cnt;
  logic [HIST_W-1:0]  rd_data;
  logic [TBL_AW-1:0]  rd_idx;
  logic               rd_vld;

  logic [PROD_W-1:0]  a10, a11, l10, l11;
  logic               grew, shrank;
  logic [HIST_W-1:0]  hist_next;
  logic [HIST_W-1:0]  diff;
  logic               exact, match;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_count <= '0;
    end else if (cfg_we) begin
      pattern_count <= cfg_wdata;
    end
  end

  assign limit = (pattern_count > CNT_W'(MAX_PATTERNS)) ? CNT_W'(MAX_PATTERNS)
                                                         : pattern_count;

  // area*10, area*11, prev_area*10 and prev_area*11 by shift-add
  assign a10 = (PROD_W'(area_q) << 3) + (PROD_W'(area_q) << 1);
  assign a11 = a10 + PROD_W'(area_q);
  assign l10 = (PROD_W'(prev_area_q) << 3) + (PROD_W'(prev_area_q) << 1);
  assign l11 = l10 + PROD_W'(prev_area_q);
  assign grew   = a10 > l11;
  assign shrank = a11 < l10;

  always_comb begin
    if (age_q == '0) begin
      hist_next = old_q;
    end else if (grew) begin
      hist_next = {1'b1, old_q[HIST_W-1:1]};
    end else if (shrank) begin
      hist_next = {1'b0, old_q[HIST_W-1:1]};
    end else begin
      hist_next = {old_q[HIST_W-1], old_q[HIST_W-1:1]};
    end
  end

  assign diff  = rd_data ^ rot_q;
  assign exact = (diff == '0);
  // zero or exactly one differing bit
  assign match = ((diff & (diff - 1'b1)) == '0);

  assign sts.is_write    = func;
  assign sts.skip_search = age_q < AGE_MATURE;
  assign sts.empty       = (limit == '0);
  assign sts.hit         = rd_vld && match;
  assign sts.last        = rd_vld && (CNT_W'(rd_idx) == limit - 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.tbl_write && (int'(table_index) < MAX_PATTERNS)) begin
      tbl_mem[table_index[TBL_AW-1:0]] <= table_value;
    end
    rd_data <= tbl_mem[cnt];
    rd_idx  <= cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      cnt    <= '0;
    end else begin
      rd_vld <= cmd.search;
      if (cmd.search_start) begin
        cnt <= '0;
      end else if (cmd.search) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      area_q      <= area;
      prev_area_q <= prev_area;
      age_q       <= age;
      old_q       <= old_pattern;
      phase_q     <= phase;
      frame_end_q <= last_in_frame;
    end
    if (cmd.update) begin
      hist_q <= hist_next;
      rot_q  <= rotl_hist(hist_next, rot_amount(phase_q));
      res_id <= '0;
      if (age_q == '0) begin
        res_status <= ST_NEW;
      end else if (age_q < AGE_MATURE) begin
        res_status <= ST_REC;
      end else begin
        res_status <= ST_NONE;
      end
    end else if (cmd.capture) begin
      res_status <= exact ? ST_EXACT : ST_NEAR;
      res_id     <= rd_idx;
    end
    if (cmd.out_load) begin
      new_pattern <= hist_q;
      status      <= res_status;
      led_id      <= IDX_W'(res_id);
      frame_end   <= frame_end_q;
    end
  end

endmodule

`default_nettype wire

### design/led_blink_pattern_identifier.sv
// an accepted observation is loaded, then the update state forms the new history;
// mature blobs with a non-empty table then search the entries in order up to
// limit, stopping at the first hit, where limit is pattern_count capped at MAX_PATTERNS;
// the result register loads in the finish state once it is free. One observation at
// a time; table writes are taken in the idle state without leaving it
// reset: rst (synchronous) clears pattern_count, controller and result valid
`default_nettype none

module led_blink_pattern_identifier
  import lbpi_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata,
  lbpi_item_if.sink             item,
  lbpi_result_if.source         result
);

  lbpi_cmd_t           cmd;
  lbpi_sts_t           sts;
  logic                in_ready;
  logic                out_valid;
  logic [HIST_W-1:0]   new_pattern;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    led_id;
  logic                frame_end;

  lbpi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (result.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lbpi_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .func          (item.func),
    .area          (item.area),
    .prev_area     (item.prev_area),
    .age           (item.age),
    .old_pattern   (item.old_pattern),
    .phase         (item.phase),
    .last_in_frame (item.last_in_frame),
    .table_index   (item.table_index),
    .table_value   (item.table_value),
    .cmd           (cmd),
    .sts           (sts),
    .new_pattern   (new_pattern),
    .status        (status),
    .led_id        (led_id),
    .frame_end     (frame_end)
  );

  assign item.ready         = in_ready;
  assign result.valid       = out_valid;
  assign result.new_pattern = new_pattern;
  assign result.status      = status;
  assign result.led_id      = led_id;
  assign result.frame_end   = frame_end;

endmodule

`default_nettype wire

### tb/sv/led_blink_pattern_identifier_tb.sv
module led_blink_pattern_identifier_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lbpi_pkg::*;

  localparam logic FUNC_OBSERVE  = 1'b0;
  localparam logic FUNC_TABLE_WR = 1'b1;
  localparam int   SETTLE_CYCLES = MAX_PATTERNS + 16;

  typedef struct packed {
    logic                func;
    logic [AREA_W-1:0]   area;
    logic [AREA_W-1:0]   prev_area;
    logic [AGE_W-1:0]    age;
    logic [HIST_W-1:0]   old_pattern;
    logic [PHASE_W-1:0]  phase;
    logic                last_in_frame;
    logic [IDX_W-1:0]    table_index;
    logic [HIST_W-1:0]   table_value;
  } blob_item_t;

  typedef struct packed {
    logic [HIST_W-1:0] new_pattern;
    lbpi_status_t      status;
    logic [IDX_W-1:0]  led_id;
    logic              frame_end;
  } blob_result_t;

  typedef struct packed {
    logic                func;
    logic [AREA_W-1:0]   area;
    logic [AREA_W-1:0]   prev_area;
    logic [AGE_W-1:0]    age;
    logic [HIST_W-1:0]   old_pattern;
    logic [PHASE_W-1:0]  phase;
    logic                last_in_frame;
    logic [IDX_W-1:0]    table_index;
    logic [HIST_W-1:0]   table_value;
    logic                typed;
    logic [HIST_W-1:0]   exp_pattern;
    lbpi_status_t        exp_status;
    logic [IDX_W-1:0]    exp_id;
  } blob_row_t;

  // func area prev_area age old phase last idx value | typed pattern status id
  localparam blob_row_t DIRECTED_ROWS [22] = '{
    '{FUNC_TABLE_WR, 'h0, 'h0, 'd0, 'h000, 'd0, 1'b0, 'd0, 'h155, 1'b0, 'h000, ST_NEW, 'd0},
    '{FUNC_TABLE_WR, 'h0, 'h0, 'd0, 'h000, 'd0, 1'b0, 'd1, 'h0f0, 1'b0, 'h000, ST_NEW, 'd0},
    '{FUNC_TABLE_WR, 'h0, 'h0, 'd0, 'h000, 'd0, 1'b0, 'd2, 'h3ff, 1'b0, 'h000, ST_NEW, 'd0},
    '{FUNC_TABLE_WR, 'h0, 'h0, 'd0, 'h000, 'd0, 1'b0, 'd3, 'h000, 1'b0, 'h000, ST_NEW, 'd0},
    '{FUNC_TABLE_WR, 'h0, 'h0, 'd0, 'h000, 'd0, 1'b0, 'd63, 'h3ff, 1'b0, 'h000, ST_NEW, 'd0},
    // new blobs pass the history through
    '{FUNC_OBSERVE, 'hfffff, 'h0, 'd0, 'h3ff, 'd0, 1'b1, 'd0, 'h000, 1'b1, 'h3ff, ST_NEW, 'd0},
    '{FUNC_OBSERVE, 'h0, 'hfffff, 'd0, 'h000, 'd15, 1'b0, 'd0, 'h000, 1'b1, 'h000, ST_NEW, 'd0},
    // young blobs: steady, rising, falling and the 10 percent boundaries
    '{FUNC_OBSERVE, 'h0, 'h0, 'd1, 'h3ff, 'd0, 1'b0, 'd0, 'h000, 1'b1, 'h3ff, ST_REC, 'd0},
    '{FUNC_OBSERVE, 'hfffff, 'h0, 'd8, 'h000, 'd3, 1'b1, 'd0, 'h000, 1'b1, 'h200, ST_REC, 'd0},
    '{FUNC_OBSERVE, 'h0, 'hfffff, 'd5, 'h3ff, 'd7, 1'b0, 'd0, 'h000, 1'b1, 'h1ff, ST_REC, 'd0},
    '{FUNC_OBSERVE, 'd11, 'd10, 'd3, 'h200, 'd1, 1'b0, 'd0, 'h000, 1'b1, 'h300, ST_REC, 'd0},
    '{FUNC_OBSERVE, 'd12, 'd10, 'd3, 'h000, 'd1, 1'b0, 'd0, 'h000, 1'b1, 'h200, ST_REC, 'd0},
    '{FUNC_OBSERVE, 'd9, 'd10, 'd3, 'h200, 'd1, 1'b0, 'd0, 'h000, 1'b1, 'h100, ST_REC, 'd0},
    '{FUNC_OBSERVE, 'd10, 'd11, 'd4, 'h201, 'd2, 1'b1, 'd0, 'h000, 1'b1, 'h300, ST_REC, 'd0},
    // mature blobs searched against entries 0..3
    '{FUNC_OBSERVE, 'd7, 'd7, 'd9, 'h3ff, 'd4, 1'b0, 'd0, 'h000, 1'b1, 'h3ff, ST_EXACT, 'd2},
    '{FUNC_OBSERVE, 'h0, 'h0, 'd255, 'h000, 'd9, 1'b1, 'd0, 'h000, 1'b1, 'h000, ST_EXACT, 'd3},
    '{FUNC_OBSERVE, 'd5, 'd5, 'd9, 'h002, 'd9, 1'b0, 'd0, 'h000, 1'b0, 'h000, ST_NEW, 'd0},
    '{FUNC_OBSERVE, 'h80000, 'h1000, 'd200, 'h2aa, 'd15, 1'b0, 'd0, 'h000, 1'b0, 'h000, ST_NEW, 'd0},
    '{FUNC_OBSERVE, 'h100, 'h200, 'd9, 'h155, 'd10, 1'b1, 'd0, 'h000, 1'b0, 'h000, ST_NEW, 'd0},
    '{FUNC_OBSERVE, 'd3, 'd3, 'd9, 'h1fe, 'd9, 1'b0, 'd0, 'h000, 1'b0, 'h000, ST_NEW, 'd0},
    '{FUNC_OBSERVE, 'd12, 'd10, 'd12, 'h154, 'd0, 1'b0, 'd0, 'h000, 1'b0, 'h000, ST_NEW, 'd0},
    '{FUNC_OBSERVE, 'hfffff, 'hfffff, 'd9, 'h3ff, 'd9, 1'b1, 'd63, 'h3ff, 1'b0, 'h000, ST_NEW, 'd0}
  };

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  lbpi_item_if   item_if();
  lbpi_result_if result_if();

  led_blink_pattern_identifier dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item      (item_if),
    .result    (result_if)
  );

  logic [HIST_W-1:0] led_table [MAX_PATTERNS];
  int               searched_count = 0;
  blob_result_t     awaited_results [$];
  blob_result_t     want;
  int               mismatches = 0;
  bit               calm = 1'b0;
  bit               hold_off_req = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [HIST_W-1:0] rotl10(input logic [HIST_W-1:0] h, input int r);
    return (h << r) | (h >> (HIST_W - r));
  endfunction

  function automatic blob_result_t identify_blob(input blob_item_t it);
    blob_result_t      res;
    logic [HIST_W-1:0] rot;
    int                limit;
    bit                found;
    res.new_pattern = it.old_pattern;
    res.status      = ST_NEW;
    res.led_id      = '0;
    res.frame_end   = it.last_in_frame;
    found           = 1'b0;
    if (it.age != 0) begin
      res.new_pattern = {it.old_pattern[HIST_W-1], it.old_pattern[HIST_W-1:1]};
      if (longint'(it.area) * 10 > longint'(it.prev_area) * 11) begin
        res.new_pattern[HIST_W-1] = 1'b1;
      end else if (longint'(it.area) * 11 < longint'(it.prev_area) * 10) begin
        res.new_pattern[HIST_W-1] = 1'b0;
      end
      if (it.age < AGE_MATURE) begin
        res.status = ST_REC;
      end else begin
        rot   = rotl10(res.new_pattern, (int'(it.phase) + 1) % HIST_W);
        limit = (searched_count > MAX_PATTERNS) ? MAX_PATTERNS : searched_count;
        res.status = ST_NONE;
        for (int i = 0; i < limit; i++) begin
          if (!found && $countones(led_table[i] ^ rot) < 2) begin
            found      = 1'b1;
            res.led_id = IDX_W'(i);
            if (led_table[i] == rot) begin
              res.status = ST_EXACT;
            end else begin
              res.status = ST_NEAR;
            end
          end
        end
      end
    end
    return res;
  endfunction

  task automatic offer(input blob_item_t it, input logic typed, input blob_result_t typed_res);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      item_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_if.valid         <= 1'b1;
    item_if.func          <= it.func;
    item_if.area          <= it.area;
    item_if.prev_area     <= it.prev_area;
    item_if.age           <= it.age;
    item_if.old_pattern   <= it.old_pattern;
    item_if.phase         <= it.phase;
    item_if.last_in_frame <= it.last_in_frame;
    item_if.table_index   <= it.table_index;
    item_if.table_value   <= it.table_value;
    do @(posedge clk); while (item_if.ready !== 1'b1);
    if (it.func == FUNC_TABLE_WR) begin
      led_table[it.table_index] = it.table_value;
    end else if (typed) begin
      awaited_results.push_back(typed_res);
    end else begin
      awaited_results.push_back(identify_blob(it));
    end
  endtask

  // drop valid, drain all results, then give an in-flight search time to finish
  task automatic settle();
    @(negedge clk);
    item_if.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_patterns(input int count);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CNT_W'(count);
    @(negedge clk);
    cfg_we    <= 1'b0;
    searched_count = count;
  endtask

  task automatic run_phase(input int count);
    blob_item_t        it;
    logic [95:0]       noise;
    logic [HIST_W-1:0] target;
    logic [HIST_W-1:0] hist;
    int                pick;
    int                limit;
    int                r;
    int                base;
    for (int n = 0; n < count; n++) begin
      noise   = {$urandom, $urandom, $urandom};
      it      = noise[$bits(blob_item_t)-1:0];
      it.func = FUNC_OBSERVE;
      pick    = $urandom_range(0, 99);
      if (pick < 8) begin
        it.func = FUNC_TABLE_WR;
      end else if (pick < 20) begin
        it.age = AGE_W'($urandom_range(0, AGE_MATURE - 1));
      end else if (pick >= 45) begin
        // aim the history at a searched table entry if any, sometimes one bit off
        it.age = AGE_W'($urandom_range(AGE_MATURE, 255));
        limit  = (searched_count > MAX_PATTERNS) ? MAX_PATTERNS : searched_count;
        if (limit > 0) begin
          target = led_table[$urandom_range(0, limit - 1)];
        end else begin
          target = HIST_W'($urandom);
        end
        if ($urandom_range(0, 1) == 1) begin
          target ^= HIST_W'(1) << $urandom_range(0, HIST_W - 1);
        end
        r    = (int'(it.phase) + 1) % HIST_W;
        hist = rotl10(target, (HIST_W - r) % HIST_W);
        it.old_pattern = {hist[HIST_W-2:0], noise[95]};
        if (hist[HIST_W-1] == hist[HIST_W-2] && $urandom_range(0, 1) == 1) begin
          it.prev_area = it.area;
        end else if (hist[HIST_W-1]) begin
          base         = $urandom_range(1, 800000);
          it.prev_area = AREA_W'(base);
          it.area      = AREA_W'(base + base / 5 + 1);
        end else begin
          base         = $urandom_range(0, 800000);
          it.area      = AREA_W'(base);
          it.prev_area = AREA_W'(base + base / 5 + 1);
        end
      end
      offer(it, 1'b0, '0);
    end
  endtask

  initial begin
    int gap;
    result_if.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        // long stall so the block backs up and refuses input
        hold_off_req = 1'b0;
        result_if.ready <= 1'b0;
        repeat (399) @(negedge clk);
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 11);
        result_if.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_if.valid === 1'b1 && result_if.ready === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $error("result transaction with nothing expected");
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        if (result_if.new_pattern !== want.new_pattern) begin
          $error("new_pattern expected %0h got %0h", want.new_pattern, result_if.new_pattern);
          mismatches++;
        end
        if (result_if.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, result_if.status);
          mismatches++;
        end
        if (result_if.led_id !== want.led_id) begin
          $error("led_id expected %0d got %0d", want.led_id, result_if.led_id);
          mismatches++;
        end
        if (result_if.frame_end !== want.frame_end) begin
          $error("frame_end expected %0b got %0b", want.frame_end, result_if.frame_end);
          mismatches++;
        end
      end
    end
  end

  initial begin
    blob_row_t    row;
    blob_item_t   it;
    blob_result_t exp;
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_wdata             <= '0;
    item_if.valid         <= 1'b0;
    item_if.func          <= FUNC_OBSERVE;
    item_if.area          <= '0;
    item_if.prev_area     <= '0;
    item_if.age           <= '0;
    item_if.old_pattern   <= '0;
    item_if.phase         <= '0;
    item_if.last_in_frame <= 1'b0;
    item_if.table_index   <= '0;
    item_if.table_value   <= '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    set_patterns(4);
    foreach (DIRECTED_ROWS[i]) begin
      row              = DIRECTED_ROWS[i];
      it.func          = row.func;
      it.area          = row.area;
      it.prev_area     = row.prev_area;
      it.age           = row.age;
      it.old_pattern   = row.old_pattern;
      it.phase         = row.phase;
      it.last_in_frame = row.last_in_frame;
      it.table_index   = row.table_index;
      it.table_value   = row.table_value;
      exp.new_pattern  = row.exp_pattern;
      exp.status       = row.exp_status;
      exp.led_id       = row.exp_id;
      exp.frame_end    = row.last_in_frame;
      offer(it, row.typed, exp);
    end

    // load every entry so any count can be searched
    set_patterns(0);
    for (int i = 0; i < MAX_PATTERNS; i++) begin
      it             = '0;
      it.func        = FUNC_TABLE_WR;
      it.table_index = IDX_W'(i);
      it.table_value = HIST_W'($urandom);
      offer(it, 1'b0, '0);
    end

    set_patterns(MAX_PATTERNS);
    hold_off_req = 1'b1;
    run_phase(240);
    set_patterns(127);
    run_phase(240);
    set_patterns(1);
    run_phase(240);
    set_patterns(0);
    run_phase(240);
    set_patterns(MAX_PATTERNS + 1);
    run_phase(240);
    set_patterns($urandom_range(0, 127));
    run_phase(240);
    set_patterns(MAX_PATTERNS);
    calm = 1'b1;
    run_phase(240);
    settle();

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
